FILE: rtl/bfdt_pkg.sv
package bfdt_pkg;

  // Raw value above this shows as "***.**"
  localparam int unsigned LIMIT_RAW = 63999;

  // Scale to thousandths: value * 125 / 8
  localparam int unsigned SCALE_MUL   = 125;
  localparam int unsigned SCALE_SHIFT = 3;

  // Value range handled by the multiplier (in-range raw values fit here)
  localparam int unsigned RAW_W = 16;

  // Width of the number handed down the digit chain (thousandths plus 5)
  localparam int unsigned NUM_W = 20;

  // One divide-by-ten cell per decimal digit, thousandths first
  localparam int unsigned N_CELLS = 6;

  // Reciprocal of ten: floor(x / 10) == (x * RECIP_MUL) >> RECIP_SHIFT
  // holds for every x below 2**22, which covers NUM_W bits
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned RECIP_MUL   = (1 << RECIP_SHIFT) / 10 + 1;
  localparam int unsigned PROD_W      = 2 * NUM_W;

  // Character codes, six bits wide
  localparam int unsigned CHAR_W = 6;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_SPACE = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] CHAR_STAR  = CHAR_W'(42);
  localparam logic [CHAR_W-1:0] CHAR_POINT = CHAR_W'(46);

  // Digit slots after the last cell
  localparam int unsigned SLOT_HUNDREDTHS = 1;
  localparam int unsigned SLOT_TENTHS     = 2;
  localparam int unsigned SLOT_ONES       = 3;
  localparam int unsigned SLOT_TENS       = 4;
  localparam int unsigned SLOT_HUNDREDS   = 5;

  // Word carried from cell to cell
  typedef struct packed {
    logic                    ovf;
    logic [NUM_W-1:0]        num;
    logic [N_CELLS-1:0][3:0] dig;
  } bfdt_word_t;

  // ASCII code of one decimal digit
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    digit_char = CHAR_ZERO + CHAR_W'(d);
  endfunction

endpackage

FILE: rtl/bfdt_scale.sv
module bfdt_scale
  import bfdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_ready,
  output bfdt_word_t  out_word
);

  localparam int unsigned MUL_W = RAW_W + 7;

  logic [MUL_W-1:0] prod;
  logic [NUM_W-1:0] milli;
  bfdt_word_t       word_next;

  // Scale to thousandths and add five so the first cell rounds half up
  always_comb begin
    prod  = MUL_W'(value[RAW_W-1:0]) * MUL_W'(SCALE_MUL);
    milli = NUM_W'(prod >> SCALE_SHIFT);
    word_next.ovf = (value > 32'(LIMIT_RAW));
    word_next.num = milli + NUM_W'(5);
    word_next.dig = '0;
  end

  assign in_ready = !out_valid || out_ready;

  // Hold valid until the next cell takes the item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Load payload on every advance
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

FILE: rtl/bfdt_cell.sv
module bfdt_cell
  import bfdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  bfdt_word_t in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output bfdt_word_t out_word
);

  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  quot;
  logic [NUM_W-1:0]  rem_full;
  bfdt_word_t        word_next;

  // Divide by ten with the reciprocal, then peel off the remainder digit
  always_comb begin
    prod     = PROD_W'(in_word.num) * PROD_W'(RECIP_MUL);
    quot     = NUM_W'(prod >> RECIP_SHIFT);
    rem_full = in_word.num - ((quot << 3) + (quot << 1));
    word_next.ovf = in_word.ovf;
    word_next.num = quot;
    // Shift the new digit in at the top; earlier digits move down one slot
    word_next.dig = {rem_full[3:0], in_word.dig[N_CELLS-1:1]};
  end

  assign in_ready = !out_valid || out_ready;

  // Hold valid until the neighbor takes the item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Load payload on every advance
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_word <= word_next;
    end
  end

endmodule

FILE: rtl/binary_fixed_to_decimal_text_core.sv
// Channel   Dir  tdata fields (low bit first)                          tuser  tlast
// s_axis    in   value[31:0]                                           -      -
// m_axis    out  char_hundreds, char_tens, char_ones, char_point,      -      -
//                char_tenths, char_hundredths (6 bits each), 4 zeros
//
// One item enters per cycle unless m_tready stalls the chain; each passes through
// one scaling stage (multiply by 125) and six divide-by-ten cells, one per digit.
// Every stage has its own valid and takes a new item whenever its successor
// takes the one it holds, so a stall at m_tready only backs up full stages.
// rst clears the valid bits only; payload registers are not reset.
module binary_fixed_to_decimal_text_core
  import bfdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // char_hundreds[5:0], char_tens[11:6], char_ones[17:12], char_point[23:18],
  // char_tenths[29:24], char_hundredths[35:30], zero[39:36]
  output logic [39:0] m_tdata
);

  logic       valid [N_CELLS+1];
  logic       ready [N_CELLS+1];
  bfdt_word_t word  [N_CELLS+1];
  bfdt_word_t last;
  logic       lead_h;
  logic       lead_t;
  logic [CHAR_W-1:0] c_h, c_t, c_o, c_d1, c_d2;

  // Scale the raw value into thousandths
  bfdt_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .value    (s_tdata),
    .out_valid(valid[0]),
    .out_ready(ready[0]),
    .out_word (word[0])
  );

  // Row of divide-by-ten cells
  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    bfdt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (valid[i]),
      .in_ready (ready[i]),
      .in_word  (word[i]),
      .out_valid(valid[i+1]),
      .out_ready(ready[i+1]),
      .out_word (word[i+1])
    );
  end

  assign m_tvalid       = valid[N_CELLS];
  assign ready[N_CELLS] = m_tready;
  assign last           = word[N_CELLS];

  // Blank leading zeros, star out on overflow
  always_comb begin
    lead_h = (last.dig[SLOT_HUNDREDS] == 4'd0);
    lead_t = lead_h && (last.dig[SLOT_TENS] == 4'd0);
    if (last.ovf) begin
      c_h  = CHAR_STAR;
      c_t  = CHAR_STAR;
      c_o  = CHAR_STAR;
      c_d1 = CHAR_STAR;
      c_d2 = CHAR_STAR;
    end else begin
      c_h  = lead_h ? CHAR_SPACE : digit_char(last.dig[SLOT_HUNDREDS]);
      c_t  = lead_t ? CHAR_SPACE : digit_char(last.dig[SLOT_TENS]);
      c_o  = digit_char(last.dig[SLOT_ONES]);
      c_d1 = digit_char(last.dig[SLOT_TENTHS]);
      c_d2 = digit_char(last.dig[SLOT_HUNDREDTHS]);
    end
  end

  assign m_tdata = {4'd0, c_d2, c_d1, CHAR_POINT, c_o, c_t, c_h};

endmodule
